@@ src/adll_pkg.sv @@
// Shared constants, codes and field layouts for the array based doubly linked list.
// Depends on nothing; imported by array_doubly_linked_list_top.
`timescale 1ns / 1ps
`default_nettype none

package adll_pkg;

  localparam int SLOTS     = 256;
  localparam int SLOT_W    = 8;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int COUNT_W   = 8;
  localparam int GRP_W     = 16;
  localparam int GRP_IDX_W = 4;
  localparam int BIT_IDX_W = 4;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 88;

  localparam logic [SLOT_W-1:0]  HINT_RESET = SLOT_W'(SLOTS / 2);
  localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(SLOTS - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    ACT_PUSH_FRONT   = 4'd0,
    ACT_PUSH_BACK    = 4'd1,
    ACT_INSERT_BEFORE = 4'd2,
    ACT_INSERT_AFTER = 4'd3,
    ACT_DELETE       = 4'd4,
    ACT_FIND_VALUE   = 4'd5,
    ACT_FIND_POS     = 4'd6,
    ACT_READ_SLOT    = 4'd7,
    ACT_LINEARIZE    = 4'd8,
    ACT_CLEAR        = 4'd9
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_SENTINEL  = 3'd2,
    ST_FREE_SLOT = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DISP  = 10'b00_0000_0010,
    S_SCAN  = 10'b00_0000_0100,
    S_LINK1 = 10'b00_0000_1000,
    S_LINK2 = 10'b00_0001_0000,
    S_WALK  = 10'b00_0010_0000,
    S_CPY   = 10'b00_0100_0000,
    S_WB0   = 10'b00_1000_0000,
    S_WB    = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

@@ src/array_doubly_linked_list_top.sv @@
// Doubly linked list held in slot memories, slot 0 being the circular sentinel.
// Sequencer, link/data/scratch memories and result register; uses adll_pkg.
//
// Usage: one command item enters on the s_ channel (action, slot, value,
// position) and exactly one result item leaves on the m_ channel.
// The block takes a new item only while its sequencer is idle; one item is
// in work at a time. The result goes into an output register, so the next
// item is taken while an earlier result still waits for m_tready; a finished
// item holds in its last step until that register is free.
// Steps from acceptance to result valid:
//   read, delete, clear, errors, in-order position lookup: dispatch, finish
//   push and insert: dispatch, a search for the lowest free slot when needed
//   (16 slot-valid groups of 16, one group per cycle), the link steps, finish
//   find by value or position: dispatch, a walk over the elements (one per
//   cycle), finish
//   linearize: dispatch, a search for the lowest valid slot, a copy walk into
//   the scratch memory, then write-back of all entries, finish
// Reset (rst, synchronous) empties the list, sets the free hint to the middle
// slot and marks the list in order; no memory sweep is needed since slot
// valid bits live in flip-flops. The clear action does the same.
`timescale 1ns / 1ps
`default_nettype none

module array_doubly_linked_list_top
  import adll_pkg::*;
(
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             s_tvalid,
  output logic                   s_tready,
  // action[3:0], slot_index[11:4], value[43:12], position[51:44], zero pad
  input  wire  logic [IN_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  wire  logic             m_tready,
  // status[2:0], result_slot[10:3], slot_data[42:11], slot_next[50:43],
  // slot_prev[58:51], slot_valid[59], element_count[67:60],
  // first_slot[75:68], last_slot[83:76], zero pad
  output logic [OUT_W-1:0]       m_tdata
);

  state_t state;

  // list state
  logic [SLOTS-1:0]   valid;
  logic [SLOT_W-1:0]  head, tail, hint;
  logic [COUNT_W-1:0] count;
  logic               in_order;

  // latched command
  logic [3:0]         op;
  logic [SLOT_W-1:0]  idx;
  logic [DATA_W-1:0]  val;
  logic [POS_W-1:0]   pos;

  // work registers
  logic [SLOT_W-1:0]    ns, lk_p, lk_n, cur, start;
  logic [COUNT_W-1:0]   cnt_i, wb_j;
  logic [GRP_IDX_W-1:0] grp;

  // result fields
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot, res_next, res_prev;
  logic [DATA_W-1:0]  res_data;
  logic               res_valid;

  // memories
  logic [DATA_W-1:0] mem_data [SLOTS];
  logic [SLOT_W-1:0] mem_next [SLOTS];
  logic [SLOT_W-1:0] mem_prev [SLOTS];
  logic [DATA_W-1:0] mem_scr  [SLOTS];
  logic [DATA_W-1:0] q_data, q_scr;
  logic [SLOT_W-1:0] q_next, q_prev;

  logic [SLOT_W-1:0] rd_addr, scr_raddr;
  logic              dt_we, nx_we, pv_we, sc_we;
  logic [SLOT_W-1:0] dt_wa, nx_wa, pv_wa, sc_wa, nx_wd, pv_wd;
  logic [DATA_W-1:0] dt_wd, sc_wd;

  logic               accept, out_load;
  logic [SLOT_W-1:0]  wb_slot;
  logic [COUNT_W-1:0] wb_j1;

  // group search for the lowest free or lowest valid slot
  logic [GRP_W-1:0]     grp_bits, grp_hit;
  logic                 grp_found;
  logic [BIT_IDX_W-1:0] grp_pos;
  logic [SLOT_W-1:0]    scan_slot;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);
  assign wb_slot  = start + wb_j;
  assign wb_j1    = wb_j + COUNT_W'(1);

  always_comb begin
    grp_bits = valid[{grp, 4'b0000} +: GRP_W];
    if (op == ACT_LINEARIZE) begin
      grp_hit = grp_bits;
    end else begin
      grp_hit = ~grp_bits;
      if (grp == '0) grp_hit[0] = 1'b0;  // sentinel is never free
    end
    grp_found = 1'b0;
    grp_pos   = '0;
    for (int k = GRP_W - 1; k >= 0; k--) begin
      if (grp_hit[k]) begin
        grp_found = 1'b1;
        grp_pos   = BIT_IDX_W'(k);
      end
    end
    scan_slot = {grp, grp_pos};
  end

  always_comb begin
    case (state)
      S_IDLE:        rd_addr = s_tdata[11:4];
      S_WALK, S_CPY: rd_addr = q_next;
      default:       rd_addr = head;
    endcase
    scr_raddr = (state == S_WB) ? SLOT_W'(wb_j1) : '0;
  end

  // memory write ports
  always_comb begin
    dt_we = 1'b0; dt_wa = ns; dt_wd = val;
    nx_we = 1'b0; nx_wa = ns; nx_wd = lk_n;
    pv_we = 1'b0; pv_wa = ns; pv_wd = lk_p;
    sc_we = 1'b0; sc_wa = SLOT_W'(cnt_i - COUNT_W'(1)); sc_wd = q_data;
    case (state)
      S_DISP: begin
        if (op == ACT_DELETE && idx != '0 && valid[idx]) begin
          nx_we = (q_prev != '0); nx_wa = q_prev; nx_wd = q_next;
          pv_we = (q_next != '0); pv_wa = q_next; pv_wd = q_prev;
        end
      end
      S_LINK1: begin
        dt_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
      end
      S_LINK2: begin
        nx_we = (lk_p != '0); nx_wa = lk_p; nx_wd = ns;
        pv_we = (lk_n != '0); pv_wa = lk_n; pv_wd = ns;
      end
      S_CPY: sc_we = 1'b1;
      S_WB: begin
        dt_we = 1'b1; dt_wa = wb_slot; dt_wd = q_scr;
        nx_we = 1'b1; nx_wa = wb_slot;
        nx_wd = (wb_j1 == count) ? '0 : wb_slot + SLOT_W'(1);
        pv_we = 1'b1; pv_wa = wb_slot;
        pv_wd = (wb_j == '0) ? '0 : wb_slot - SLOT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dt_we) mem_data[dt_wa] <= dt_wd;
    if (nx_we) mem_next[nx_wa] <= nx_wd;
    if (pv_we) mem_prev[pv_wa] <= pv_wd;
    if (sc_we) mem_scr[sc_wa]  <= sc_wd;
    q_data <= mem_data[rd_addr];
    q_next <= mem_next[rd_addr];
    q_prev <= mem_prev[rd_addr];
    q_scr  <= mem_scr[scr_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      head     <= '0;
      tail     <= '0;
      hint     <= HINT_RESET;
      count    <= '0;
      in_order <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= s_tdata[3:0];
            idx   <= s_tdata[11:4];
            val   <= s_tdata[43:12];
            pos   <= s_tdata[51:44];
            state <= S_DISP;
          end
        end

        S_DISP: begin
          res_status <= ST_OK;
          res_slot   <= '0;
          res_data   <= '0;
          res_next   <= '0;
          res_prev   <= '0;
          res_valid  <= 1'b0;
          grp        <= '0;
          cur        <= head;
          cnt_i      <= COUNT_W'(1);
          state      <= S_FIN;
          case (op)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (count >= FULL_COUNT) begin
                res_status <= ST_FULL;
              end else begin
                if (op == ACT_PUSH_FRONT) begin
                  lk_p <= '0; lk_n <= head;
                end else begin
                  lk_p <= tail; lk_n <= '0;
                end
                if (op == ACT_PUSH_FRONT && in_order && head > SLOT_W'(1) &&
                    !valid[head - SLOT_W'(1)]) begin
                  ns <= head - SLOT_W'(1); state <= S_LINK1;
                end else if (op == ACT_PUSH_BACK && in_order && tail < LAST_SLOT &&
                             !valid[tail + SLOT_W'(1)]) begin
                  ns <= tail + SLOT_W'(1); state <= S_LINK1;
                end else if (count != '0) begin
                  in_order <= 1'b0; state <= S_SCAN;
                end else begin
                  ns <= hint; state <= S_LINK1;
                end
              end
            end
            ACT_INSERT_BEFORE, ACT_INSERT_AFTER: begin
              if (idx != '0 && !valid[idx]) begin
                res_status <= ST_FREE_SLOT;
              end else if (count >= FULL_COUNT) begin
                res_status <= ST_FULL;
              end else begin
                in_order <= 1'b0;
                if (op == ACT_INSERT_BEFORE) begin
                  lk_p <= (idx == '0) ? tail : q_prev; lk_n <= idx;
                end else begin
                  lk_p <= idx; lk_n <= (idx == '0) ? head : q_next;
                end
                if (op == ACT_INSERT_BEFORE && idx > SLOT_W'(1) &&
                    !valid[idx - SLOT_W'(1)]) begin
                  ns <= idx - SLOT_W'(1); state <= S_LINK1;
                end else if (op == ACT_INSERT_AFTER && idx < LAST_SLOT &&
                             !valid[idx + SLOT_W'(1)]) begin
                  ns <= idx + SLOT_W'(1); state <= S_LINK1;
                end else if (count != '0) begin
                  state <= S_SCAN;
                end else begin
                  ns <= hint; state <= S_LINK1;
                end
              end
            end
            ACT_DELETE: begin
              if (idx == '0) begin
                res_status <= ST_SENTINEL;
              end else if (!valid[idx]) begin
                res_status <= ST_FREE_SLOT;
              end else begin
                if (idx != head && idx != tail) in_order <= 1'b0;
                if (q_prev == '0) head <= q_next;
                if (q_next == '0) tail <= q_prev;
                valid[idx] <= 1'b0;
                count      <= count - COUNT_W'(1);
                res_slot   <= idx;
              end
            end
            ACT_FIND_VALUE: begin
              if (count == '0) res_status <= ST_NOT_FOUND;
              else state <= S_WALK;
            end
            ACT_FIND_POS: begin
              if (in_order) begin
                res_slot <= head + pos - SLOT_W'(1);
              end else if (pos == '0 || pos > count) begin
                res_status <= ST_NOT_FOUND;
              end else begin
                state <= S_WALK;
              end
            end
            ACT_READ_SLOT: begin
              res_slot <= idx;
              if (idx == '0) begin
                res_next <= head;
                res_prev <= tail;
              end else if (valid[idx]) begin
                res_valid <= 1'b1;
                res_data  <= q_data;
                res_next  <= q_next;
                res_prev  <= q_prev;
              end
            end
            ACT_LINEARIZE: begin
              res_slot <= head;
              if (!in_order) begin
                if (count == '0) in_order <= 1'b1;
                else state <= S_SCAN;
              end
            end
            ACT_CLEAR: begin
              valid    <= '0;
              head     <= '0;
              tail     <= '0;
              hint     <= HINT_RESET;
              count    <= '0;
              in_order <= 1'b1;
            end
            default: ;
          endcase
        end

        S_SCAN: begin
          if (grp_found) begin
            if (op == ACT_LINEARIZE) begin
              start <= scan_slot;
              state <= S_CPY;
            end else begin
              ns    <= scan_slot;
              state <= S_LINK1;
            end
          end else begin
            grp <= grp + GRP_IDX_W'(1);
          end
        end

        S_LINK1: begin
          valid[ns] <= 1'b1;
          count     <= count + COUNT_W'(1);
          hint      <= ns;
          res_slot  <= ns;
          state     <= S_LINK2;
        end

        S_LINK2: begin
          if (lk_p == '0) head <= ns;
          if (lk_n == '0) tail <= ns;
          state <= S_FIN;
        end

        S_WALK: begin
          if (op == ACT_FIND_VALUE && q_data == val) begin
            res_slot <= cur;
            state    <= S_FIN;
          end else if (op == ACT_FIND_POS && cnt_i == pos) begin
            res_slot <= cur;
            state    <= S_FIN;
          end else if (cnt_i == count) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_FIN;
          end else begin
            cur   <= q_next;
            cnt_i <= cnt_i + COUNT_W'(1);
          end
        end

        S_CPY: begin
          if (cnt_i == count) state <= S_WB0;
          else cnt_i <= cnt_i + COUNT_W'(1);
        end

        S_WB0: begin
          for (int k = 0; k < SLOTS; k++) begin
            valid[k] <= ({1'b0, SLOT_W'(k)} >= {1'b0, start}) &&
                        ({1'b0, SLOT_W'(k)} < ({1'b0, start} + {1'b0, count}));
          end
          head     <= start;
          tail     <= start + count - SLOT_W'(1);
          in_order <= 1'b1;
          res_slot <= start;
          wb_j     <= '0;
          state    <= S_WB;
        end

        S_WB: begin
          if (wb_j1 == count) state <= S_FIN;
          else wb_j <= wb_j1;
        end

        S_FIN: begin
          if (out_load) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0000, tail, head, count, res_valid, res_prev, res_next,
                  res_data, res_slot, res_status};
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_sentinel: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == '0 && tail == '0))
    else $error("empty list with sentinel links not pointing to itself");

  a_link_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK2) |-> valid[ns])
    else $error("new slot not marked valid while linking neighbors");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (cur != '0 && count != '0))
    else $error("list walk reached the sentinel");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!m_tvalid || m_tready)) |=> (state == S_IDLE && m_tvalid))
    else $error("finished item not handed to the output register");
`endif

endmodule

`default_nettype wire
